// ----- rtl/kq_pkg.sv -----
// Shared types and constants for the key event queue.
// Depends on nothing; every rtl file uses it by scoped names.
package kq_pkg;

    // input word
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] key_code;
        logic       pressed;
    } in_word_t;

    // result word
    typedef struct packed {
        logic       event_valid;
        logic       event_pressed;
        logic [7:0] event_key;
        logic [5:0] queue_count;
        logic       dropped;
    } out_word_t;

    // command codes
    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [9:0] DELAY_RST  = 10'd1000;
    localparam logic [8:0] PERIOD_RST = 9'd400;

    localparam int EVT_W = 9;   // bit 8 down flag, bits 7..0 key

    // controller -> datapath
    typedef struct packed {
        logic start;      // word accepted, latch payload, clear flags
        logic key_push;   // key change: push event, update held key
        logic tick_inc;   // advance millisecond counter
        logic tick_fire;  // repeat check, push repeat event
        logic pop;        // read oldest event
        logic load;       // load result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // result register empty or draining
    } dp_stat_t;

endpackage

// ----- rtl/key_event_queue_with_autorepeat.sv -----
// Keyboard event queue with typematic auto-repeat.
// Sequence: key change and pop pass through their own state, tick through the tick
// and fire states, the unused command straight to finish; items are taken one at a
// time, as set by the controller sequence and the registered read for a pop.
// Reset (rst_n, async low) clears pointers, held key, timers and control;
// the event memory is not cleared, unread entries are never returned.
module key_event_queue_with_autorepeat
#(
    parameter int QUEUE_DEPTH = 64   // ring slots, one stays empty
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  kq_pkg::in_word_t  in_word,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output kq_pkg::out_word_t out_word,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [9:0]       repeat_delay_ms;
    logic [8:0]       repeat_period_ms;
    kq_pkg::ctl_cmd_t cmd;
    kq_pkg::dp_stat_t stat;

    // delay and period registers
    kq_regs u_regs
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .repeat_delay_ms  (repeat_delay_ms),
        .repeat_period_ms (repeat_period_ms)
    );

    // sequencer: idle -> key | tick,fire | pop | straight on for nop -> finish (waits for free
    // result register) -> idle
    kq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_word.command),
        .in_stall   (in_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // ring memory, timers and the output word register; the result register
    // lets the next word be accepted while a finished one waits downstream
    kq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_word          (in_word),
        .repeat_delay_ms  (repeat_delay_ms),
        .repeat_period_ms (repeat_period_ms),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_word         (out_word)
    );

endmodule

// ----- rtl/kq_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on kq_pkg.
module kq_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [9:0]  repeat_delay_ms,
    output logic [8:0]  repeat_period_ms
);

    logic [9:0] delay_reg;
    logic [8:0] period_reg;
    logic       wr_en;
    logic       idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= kq_pkg::DELAY_RST;
            period_reg <= kq_pkg::PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                kq_pkg::REG_DELAY:  delay_reg  <= pwdata[9:0];
                kq_pkg::REG_PERIOD: period_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            kq_pkg::REG_DELAY:  prdata = {22'd0, delay_reg};
            kq_pkg::REG_PERIOD: prdata = {23'd0, period_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign repeat_delay_ms  = delay_reg;
    assign repeat_period_ms = period_reg;

endmodule

// ----- rtl/kq_ctrl.sv -----
// Sequencer for the key event queue: one item at a time.
// Depends on kq_pkg.
module kq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_command,
    output logic             in_stall,
    input  kq_pkg::dp_stat_t stat,
    output kq_pkg::ctl_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_TICK = 3'd2;
    localparam logic [2:0] ST_FIRE = 3'd3;
    localparam logic [2:0] ST_POP  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_command)
                        kq_pkg::CMD_KEY:  state_next = ST_KEY;
                        kq_pkg::CMD_TICK: state_next = ST_TICK;
                        kq_pkg::CMD_POP:  state_next = ST_POP;
                        default:          state_next = ST_FIN;
                    endcase
                end
            end
            ST_KEY:  state_next = ST_FIN;
            ST_TICK: state_next = ST_FIRE;
            ST_FIRE: state_next = ST_FIN;
            ST_POP:  state_next = ST_FIN;
            ST_FIN:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd.start     = accept;
        cmd.key_push  = (state_reg == ST_KEY);
        cmd.tick_inc  = (state_reg == ST_TICK);
        cmd.tick_fire = (state_reg == ST_FIRE);
        cmd.pop       = (state_reg == ST_POP);
        cmd.load      = (state_reg == ST_FIN) & stat.out_free;
    end

endmodule

// ----- rtl/kq_dp.sv -----
// Datapath: event ring memory, pointers, repeat timer and result register.
// Depends on kq_pkg.
module kq_dp
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  kq_pkg::in_word_t  in_word,
    input  logic [9:0]        repeat_delay_ms,
    input  logic [8:0]        repeat_period_ms,
    input  kq_pkg::ctl_cmd_t  cmd,
    output kq_pkg::dp_stat_t  stat,
    output logic              out_valid,
    input  logic              out_stall,
    output kq_pkg::out_word_t out_word
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = (PW > 6) ? PW : 6;
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    logic [kq_pkg::EVT_W-1:0] mem [QUEUE_DEPTH];
    logic [kq_pkg::EVT_W-1:0] mem_q;

    logic [PW-1:0] rd_ptr_reg, wr_ptr_reg, cnt_reg;
    logic [7:0]    held_reg;
    logic [31:0]   now_reg, press_reg, last_reg;
    logic          lost_reg, popv_reg, out_valid_reg;
    logic [7:0]    key_reg;
    logic          pressed_reg;
    kq_pkg::out_word_t out_reg;

    logic          full, fire, push_en, do_write, do_read;
    logic [31:0]   elapsed, limit;
    logic [PW-1:0] wr_ptr_next, rd_ptr_next;
    logic [kq_pkg::EVT_W-1:0] push_data;
    logic [CW-1:0] cnt_ext;

    assign full        = (cnt_reg == LAST);
    assign wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;

    // last == press means no repeat yet; then now-last equals now-press
    assign elapsed = now_reg - last_reg;
    assign limit   = (last_reg == press_reg) ? {22'd0, repeat_delay_ms}
                                             : {23'd0, repeat_period_ms};
    assign fire    = (held_reg != 8'd0) && (elapsed >= limit);

    assign push_en   = cmd.key_push | (cmd.tick_fire & fire);
    assign push_data = cmd.key_push ? {pressed_reg, key_reg} : {1'b1, held_reg};
    assign do_write  = push_en & ~full;
    assign do_read   = cmd.pop & (cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_ptr_reg] <= push_data;
        if (do_read)
            mem_q <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg     <= in_word.key_code;
            pressed_reg <= in_word.pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
            held_reg   <= '0;
            now_reg    <= '0;
            press_reg  <= '0;
            last_reg   <= '0;
            lost_reg   <= 1'b0;
            popv_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                lost_reg <= 1'b0;
                popv_reg <= 1'b0;
            end
            if (push_en)
                lost_reg <= full;
            if (do_write)
            begin
                wr_ptr_reg <= wr_ptr_next;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            if (cmd.key_push)
            begin
                if (pressed_reg)
                begin
                    held_reg  <= key_reg;
                    press_reg <= now_reg;
                    last_reg  <= now_reg;
                end
                else if (key_reg == held_reg)
                    held_reg <= '0;
            end
            if (cmd.tick_inc)
                now_reg <= now_reg + 32'd1;
            if (cmd.tick_fire & fire)
                last_reg <= now_reg;
            if (do_read)
            begin
                rd_ptr_reg <= rd_ptr_next;
                cnt_reg    <= cnt_reg - 1'b1;
                popv_reg   <= 1'b1;
            end
        end
    end

    assign stat.out_free = ~out_valid_reg | ~out_stall;
    assign cnt_ext       = CW'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg.event_valid   <= popv_reg;
            out_reg.event_pressed <= popv_reg & mem_q[8];
            out_reg.event_key     <= popv_reg ? mem_q[7:0] : 8'd0;
            out_reg.queue_count   <= cnt_ext[5:0];
            out_reg.dropped       <= lost_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ----- rtl/kq_checker.sv -----
// Port-level checks for the key event queue, bound to the top level.
// Depends on kq_pkg and key_event_queue_with_autorepeat.
module kq_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input kq_pkg::out_word_t out_word
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // no popped event means empty event fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.event_valid |->
            !out_word.event_pressed && (out_word.event_key == 8'd0))
        else $error("event fields set without a popped event");

    // a pop never pushes, so it cannot drop
    a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.event_valid |-> !out_word.dropped)
        else $error("popped word flagged as dropped");

    // one item at a time: a taken word stalls the input next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

endmodule

bind key_event_queue_with_autorepeat kq_checker u_kq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
